FILE: hw/rtl/pid_controller_clamped_macros.svh
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_CLAMPED_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_MACROS_SVH

`ifndef SYNTH
`define PIDC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PIDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PIDC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define PIDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/pidc_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Widths, fixed-point constants and register map of the clamped PID block.
// ----------------------------------------------------------------------------
package pidc_pkg;

    localparam int IN_W    = 16;
    localparam int ERR_W   = 17;
    localparam int DIFF_W  = 18;
    localparam int SUM_W   = 24;
    localparam int FILT_W  = 34;
    localparam int FSUM_W  = 35;
    localparam int OPA_W   = 35;
    localparam int OPB_W   = 17;
    localparam int PROD_W  = OPA_W + OPB_W;
    localparam int ACC_W   = 58;
    localparam int DRIVE_W = 13;
    localparam int GAIN_W  = 16;
    localparam int LIM_W   = 23;
    localparam int FRAC_SH = 15;

    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [OPB_W-1:0] ALPHA_ONE = OPB_W'(32768);

    localparam logic signed [DRIVE_W-1:0] OUT_LIMIT     = DRIVE_W'(3840);
    localparam logic signed [ACC_W-1:0]   ACC_HI        = ACC_W'(3840 * 32768);
    localparam logic signed [ACC_W-1:0]   ACC_ROUND_BIAS = ACC_W'(16384);

    localparam logic [GAIN_W-1:0] RST_KP    = GAIN_W'(5120);
    localparam logic [GAIN_W-1:0] RST_KI    = GAIN_W'(0);
    localparam logic [GAIN_W-1:0] RST_KD    = GAIN_W'(1280);
    localparam logic [GAIN_W-1:0] RST_ALPHA = GAIN_W'(16384);
    localparam logic [LIM_W-1:0]  RST_LIMIT = LIM_W'(1000);

    typedef enum logic [2:0] {
        REG_KP    = 3'd0,
        REG_KI    = 3'd1,
        REG_KD    = 3'd2,
        REG_ALPHA = 3'd3,
        REG_LIMIT = 3'd4
    } t_reg_idx;

endpackage

FILE: hw/rtl/pid_controller_clamped.sv
// ----------------------------------------------------------------------------
// Clamped PID controller
// Positional PID with integral clamp, low-pass filtered derivative and
// saturated output, computed on one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (i_valid / o_stall) carries i_measured and i_target; result
//   beat (o_valid / i_stall) carries o_drive (1/256 units) and o_saturated.
//   Gains, filter alpha and integral limit sit on the APB port at 4*index.
//   An item is taken in idle and runs through the steps of a small
//   sequencer that feeds one 35x17 multiplier and one accumulator: filter
//   product, filter decay, Kp, Ki, Kd, final sum, round and saturate.
//   The result is registered in the last step; the next item is taken only
//   when the sequencer is back in idle, not while one is still in flight.
//   o_stall is high from the accepted beat until the sequencer is idle again.
//   If the receiver stalls, the result holds; one more item is taken and the
//   sequencer then waits in its last step until the held beat has gone.
//   Reset (synchronous, active low) clears error history, error sum and
//   filter state to zero and loads the register defaults.
// ----------------------------------------------------------------------------
module pid_controller_clamped (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic signed [pidc_pkg::IN_W-1:0]        i_measured,
    input  logic signed [pidc_pkg::IN_W-1:0]        i_target,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [pidc_pkg::DRIVE_W-1:0]     o_drive,
    output logic                                    o_saturated,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic        [pidc_pkg::ADDR_W-1:0]      paddr,
    input  logic        [pidc_pkg::DATA_W-1:0]      pwdata,
    output logic        [pidc_pkg::DATA_W-1:0]      prdata,
    output logic                                    pready
);
    import pidc_pkg::*;

`include "pid_controller_clamped_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_DECAY,
        S_FILT,
        S_KI,
        S_KD,
        S_TOTAL,
        S_OUT
    } t_state;

    // configuration
    logic [GAIN_W-1:0] r_kp;
    logic [GAIN_W-1:0] r_ki;
    logic [GAIN_W-1:0] r_kd;
    logic [GAIN_W-1:0] r_alpha;
    logic [LIM_W-1:0]  r_lim;
    t_reg_idx          cfg_idx;
    logic              cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= RST_KP;
            r_ki    <= RST_KI;
            r_kd    <= RST_KD;
            r_alpha <= RST_ALPHA;
            r_lim   <= RST_LIMIT;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_KP:    r_kp    <= pwdata[GAIN_W-1:0];
                REG_KI:    r_ki    <= pwdata[GAIN_W-1:0];
                REG_KD:    r_kd    <= pwdata[GAIN_W-1:0];
                REG_ALPHA: r_alpha <= pwdata[GAIN_W-1:0];
                REG_LIMIT: r_lim   <= pwdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_KP:    prdata = {{(DATA_W-GAIN_W){1'b0}}, r_kp};
            REG_KI:    prdata = {{(DATA_W-GAIN_W){1'b0}}, r_ki};
            REG_KD:    prdata = {{(DATA_W-GAIN_W){1'b0}}, r_kd};
            REG_ALPHA: prdata = {{(DATA_W-GAIN_W){1'b0}}, r_alpha};
            REG_LIMIT: prdata = {{(DATA_W-LIM_W){1'b0}}, r_lim};
            default:   prdata = '0;
        endcase
    end

    // datapath state
    t_state                    r_state;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [DIFF_W-1:0]  r_diff;
    logic signed [ERR_W-1:0]   r_prev;
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [FILT_W-1:0]  r_filt;
    logic signed [FSUM_W-1:0]  r_fsum;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_drive;
    logic                      r_sat;

    logic                      in_beat;
    logic                      out_free;
    logic signed [ERR_W-1:0]   n_err;
    logic signed [DIFF_W-1:0]  n_diff;
    logic [OPB_W-1:0]          alpha_c;
    logic [OPB_W-1:0]          alpha_rest;
    logic signed [SUM_W:0]     sum_raw;
    logic signed [SUM_W:0]     lim_pos;
    logic signed [SUM_W:0]     lim_neg;
    logic signed [SUM_W-1:0]   n_sum;
    logic signed [PROD_W-1:0]  decay_sh;
    logic signed [PROD_W-1:0]  filt_sum;
    logic signed [OPA_W-1:0]   mul_a;
    logic signed [OPB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [ACC_W-1:0]   acc_sh;
    logic signed [DRIVE_W-1:0] n_drive;
    logic                      n_sat;

    assign o_stall     = (r_state != S_IDLE);
    assign in_beat     = i_valid & ~o_stall;
    assign out_free    = ~r_out_valid | ~i_stall;
    assign o_valid     = r_out_valid;
    assign o_drive     = r_drive;
    assign o_saturated = r_sat;

    assign n_err  = {i_target[IN_W-1], i_target} - {i_measured[IN_W-1], i_measured};
    assign n_diff = {n_err[ERR_W-1], n_err} - {r_prev[ERR_W-1], r_prev};

    assign alpha_c    = ({1'b0, r_alpha} > ALPHA_ONE) ? ALPHA_ONE : {1'b0, r_alpha};
    assign alpha_rest = ALPHA_ONE - alpha_c;

    // integral clamp
    assign sum_raw = {r_sum[SUM_W-1], r_sum} + {{(SUM_W+1-ERR_W){r_err[ERR_W-1]}}, r_err};
    assign lim_pos = $signed({{(SUM_W+1-LIM_W){1'b0}}, r_lim});
    assign lim_neg = -lim_pos;

    always_comb begin
        if (sum_raw > lim_pos) begin
            n_sum = lim_pos[SUM_W-1:0];
        end else if (sum_raw < lim_neg) begin
            n_sum = lim_neg[SUM_W-1:0];
        end else begin
            n_sum = sum_raw[SUM_W-1:0];
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_DIFF: begin
                mul_a = {{(OPA_W-DIFF_W){r_diff[DIFF_W-1]}}, r_diff};
                mul_b = alpha_c;
            end
            S_DECAY: begin
                mul_a = {{(OPA_W-FILT_W){r_filt[FILT_W-1]}}, r_filt};
                mul_b = alpha_rest;
            end
            S_FILT: begin
                mul_a = {{(OPA_W-ERR_W){r_err[ERR_W-1]}}, r_err};
                mul_b = {1'b0, r_kp};
            end
            S_KI: begin
                mul_a = {{(OPA_W-SUM_W){r_sum[SUM_W-1]}}, r_sum};
                mul_b = {1'b0, r_ki};
            end
            S_KD: begin
                mul_a = {{(OPA_W-FILT_W){r_filt[FILT_W-1]}}, r_filt};
                mul_b = {1'b0, r_kd};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign decay_sh = r_prod >>> FRAC_SH;
    assign filt_sum = {{(PROD_W-FSUM_W){r_fsum[FSUM_W-1]}}, r_fsum} + decay_sh;
    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    // round half up, saturate at +/-15.0
    assign acc_rnd = r_acc + ACC_ROUND_BIAS;
    assign acc_sh  = acc_rnd >>> FRAC_SH;

    always_comb begin
        if (r_acc > ACC_HI) begin
            n_drive = OUT_LIMIT;
            n_sat   = 1'b1;
        end else if (r_acc < -ACC_HI) begin
            n_drive = -OUT_LIMIT;
            n_sat   = 1'b1;
        end else begin
            n_drive = acc_sh[DRIVE_W-1:0];
            n_sat   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_sum       <= '0;
            r_filt      <= '0;
        end else begin
            if (r_out_valid && !i_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_err   <= n_err;
                        r_diff  <= n_diff;
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_sum   <= n_sum;
                    r_state <= S_DECAY;
                end
                S_DECAY: begin
                    r_fsum  <= r_prod[FSUM_W-1:0];
                    r_state <= S_FILT;
                end
                S_FILT: begin
                    r_filt  <= filt_sum[FILT_W-1:0];
                    r_prev  <= r_err;
                    r_state <= S_KI;
                end
                S_KI: begin
                    r_acc   <= prod_ext;
                    r_state <= S_KD;
                end
                S_KD: begin
                    r_acc   <= r_acc + prod_ext;
                    r_state <= S_TOTAL;
                end
                S_TOTAL: begin
                    r_acc   <= (r_acc <<< FRAC_SH) + prod_ext;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_drive     <= n_drive;
                        r_sat       <= n_sat;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `PIDC_ASSERT_SAME(a_drive_range, i_clk, i_rst_n, o_valid,
        (o_drive <= OUT_LIMIT) && (o_drive >= -OUT_LIMIT), "drive out of range")
    `PIDC_ASSERT_SAME(a_sat_at_limit, i_clk, i_rst_n, o_valid && o_saturated,
        (o_drive == OUT_LIMIT) || (o_drive == -OUT_LIMIT), "saturated beat off limit")
    `PIDC_ASSERT_NEXT(a_beat_starts_seq, i_clk, i_rst_n, i_valid && !o_stall,
        r_state == S_DIFF, "input beat did not start sequencer")
    `PIDC_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, (r_state == S_OUT) && o_valid && i_stall,
        (r_state == S_OUT) && o_valid, "pending result overwritten")

endmodule

FILE: bench/tb_pid_controller_clamped.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Clamped PID controller testbench
// Writes gains, filter alpha and integral limit over APB while the block is
// idle, feeds measured/target beats with random gaps and receiver stalls, and
// checks every drive/saturated beat against a pinned value or a fixed-point
// PID predictor with its own error history, clamped error sum and filter state.
// ----------------------------------------------------------------------------
module tb_pid_controller_clamped;
    import pidc_pkg::*;

    localparam int     N_DIR          = 37;
    localparam int     N_PHASES       = 8;
    localparam int     PHASE_ITEMS    = 250;
    localparam int     QUIET_LIMIT    = 2000;
    localparam int     HOLD_CYCLES    = 300;
    localparam longint SCALE          = 32768;
    localparam longint DRIVE_MAX      = 3840;
    localparam logic [2:0] REG_SPARE5 = 3'd5;
    localparam logic [2:0] REG_SPARE7 = 3'd7;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      sat;
    } t_drive_beat;

    typedef enum logic {ROW_ITEM, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind                 kind;
        logic [2:0]                reg_sel;
        logic [31:0]               value;
        logic signed [IN_W-1:0]    meas;
        logic signed [IN_W-1:0]    tgt;
        logic                      pinned;
        logic signed [DRIVE_W-1:0] pin_drive;
        logic                      pin_sat;
    } t_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic signed [IN_W-1:0]    i_measured = '0;
    logic signed [IN_W-1:0]    i_target = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic signed [DRIVE_W-1:0] o_drive;
    logic                      o_saturated;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [ADDR_W-1:0]         paddr = '0;
    logic [DATA_W-1:0]         pwdata = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;

    // predictor configuration and state
    logic [GAIN_W-1:0]        cfg_kp = RST_KP;
    logic [GAIN_W-1:0]        cfg_ki = RST_KI;
    logic [GAIN_W-1:0]        cfg_kd = RST_KD;
    logic [GAIN_W-1:0]        cfg_alpha = RST_ALPHA;
    logic [LIM_W-1:0]         cfg_lim = RST_LIMIT;
    logic signed [ERR_W-1:0]  prev_err = '0;
    logic signed [SUM_W-1:0]  err_sum = '0;
    logic signed [FILT_W-1:0] filt_q = '0;

    t_drive_beat               pending_drive[$];
    logic                      pin_on = 1'b0;
    logic signed [DRIVE_W-1:0] pin_drive = '0;
    logic                      pin_sat = 1'b0;

    int samples_sent = 0;
    int drives_seen = 0;
    int fail_count = 0;
    int quiet_cycles = 0;
    int tx_gap_pct = 0;
    int rx_stall_pct = 0;
    int rx_burst = 0;
    int hold_left = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;

    t_row dir_rows [N_DIR];

    pid_controller_clamped dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_measured  (i_measured),
        .i_target    (i_target),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_drive     (o_drive),
        .o_saturated (o_saturated),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_drive_beat predict_drive(input logic signed [IN_W-1:0] meas,
                                                  input logic signed [IN_W-1:0] tgt);
        longint err, sum, lim, alpha, diff, filt_new, acc;
        t_drive_beat r;
        err   = longint'(tgt) - longint'(meas);
        lim   = longint'(cfg_lim);
        sum   = longint'(err_sum) + err;
        alpha = (cfg_alpha > GAIN_W'(SCALE)) ? SCALE : longint'(cfg_alpha);
        diff  = err - longint'(prev_err);
        if (sum > lim) sum = lim;
        if (sum < -lim) sum = -lim;
        err_sum  = SUM_W'(sum);
        // decay term floors towards minus infinity
        filt_new = diff * alpha + ((longint'(filt_q) * (SCALE - alpha)) >>> FRAC_SH);
        filt_q   = FILT_W'(filt_new);
        prev_err = ERR_W'(err);
        acc = (longint'(cfg_kp) * err + longint'(cfg_ki) * sum) * SCALE
            + longint'(cfg_kd) * filt_new;
        if (acc > DRIVE_MAX * SCALE) begin
            r.drive = OUT_LIMIT;
            r.sat   = 1'b1;
        end else if (acc < -DRIVE_MAX * SCALE) begin
            r.drive = -OUT_LIMIT;
            r.sat   = 1'b1;
        end else begin
            r.drive = DRIVE_W'((acc + SCALE / 2) >>> FRAC_SH);
            r.sat   = 1'b0;
        end
        return r;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_KP:    cfg_kp    = val[GAIN_W-1:0];
            REG_KI:    cfg_ki    = val[GAIN_W-1:0];
            REG_KD:    cfg_kd    = val[GAIN_W-1:0];
            REG_ALPHA: cfg_alpha = val[GAIN_W-1:0];
            REG_LIMIT: cfg_lim   = val[LIM_W-1:0];
            default:   ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_item(input logic signed [IN_W-1:0] m,
                             input logic signed [IN_W-1:0] t,
                             input logic pin, input logic signed [DRIVE_W-1:0] pdrive,
                             input logic psat);
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_measured <= m;
        i_target   <= t;
        pin_on     <= pin;
        pin_drive  <= pdrive;
        pin_sat    <= psat;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        samples_sent++;
    endtask

    // block is idle once every sent beat has its drive back
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (drives_seen < samples_sent) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // prediction on the input beat, check on the result beat
    always @(posedge i_clk) begin
        t_drive_beat want;
        if (i_rst_n && i_valid && !o_stall) begin
            want = predict_drive(i_measured, i_target);
            if (pin_on) begin
                want.drive = pin_drive;
                want.sat   = pin_sat;
            end
            pending_drive.push_back(want);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            drives_seen++;
            if (pending_drive.size() == 0) begin
                $display("%0t: unexpected beat, drive %0d saturated %0b",
                         $time, o_drive, o_saturated);
                fail_count++;
            end else begin
                want = pending_drive.pop_front();
                if (o_drive !== want.drive) begin
                    $display("%0t: drive mismatch, expected %0d, got %0d",
                             $time, want.drive, o_drive);
                    fail_count++;
                end
                if (o_saturated !== want.sat) begin
                    $display("%0t: saturated mismatch, expected %0b, got %0b",
                             $time, want.sat, o_saturated);
                    fail_count++;
                end
            end
        end
    end

    // receiver: random stall bursts plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (rx_burst > 0) begin
            rx_burst--;
            i_stall <= 1'b1;
        end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
            rx_burst = $urandom_range(0, 18);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic signed [IN_W-1:0] m;
        logic signed [IN_W-1:0] t;
        logic [31:0]            v;
        int                     tv;
        int                     sel;
        int                     mode;

        dir_rows = '{
            '{ROW_ITEM,  REG_KP,     32'd0,        0,      0,      1'b1, 0,     1'b0},
            '{ROW_ITEM,  REG_KP,     32'd0,        100,    100,    1'b1, 0,     1'b0},
            '{ROW_ITEM,  REG_KP,     32'd0,        -32768, 32767,  1'b1, 3840,  1'b1},
            '{ROW_ITEM,  REG_KP,     32'd0,        32767,  -32768, 1'b1, -3840, 1'b1},
            '{ROW_ITEM,  REG_KP,     32'd0,        1000,   1003,   1'b0, 0,     1'b0},
            '{ROW_ITEM,  REG_KP,     32'd0,        -5,     -5,     1'b0, 0,     1'b0},
            '{ROW_ITEM,  REG_KP,     32'd0,        12,     -20,    1'b0, 0,     1'b0},
            '{ROW_WRITE, REG_KP,     32'd0,        0,      0,      1'b0, 0,     1'b0},
            '{ROW_WRITE, REG_KD,     32'd0,        0,      0,      1'b0, 0,     1'b0},
            '{ROW_WRITE, REG_KI,     32'd256,      0,      0,      1'b0, 0,     1'b0},
            '{ROW_ITEM,  REG_KP,     32'd0,        0,      50,     1'b0, 0,     1'b0},
            '{ROW_WRITE, REG_LIMIT,  32'd8388607,  0,      0,      1'b0, 0,     1'b0},
            '{ROW_ITEM,  REG_KP,     32'd0,        -32768, 32767,  1'b0, 0,     1'b0},
            '{ROW_ITEM,  REG_KP,     32'd0,        -32768, 32767,  1'b0, 0,     1'b0},
            // limit lowered under a large sum: clamps on the next beat
            '{ROW_WRITE, REG_LIMIT,  32'd5,        0,      0,      1'b0, 0,     1'b0},
            '{ROW_ITEM,  REG_KP,     32'd0,        0,      1,      1'b1, 1280,  1'b0},
            '{ROW_WRITE, REG_LIMIT,  32'd0,        0,      0,      1'b0, 0,     1'b0},
            '{ROW_ITEM,  REG_KP,     32'd0,        5,      9,      1'b1, 0,     1'b0},
            // alpha above one behaves as one
            '{ROW_WRITE, REG_ALPHA,  32'd65535,    0,      0,      1'b0, 0,     1'b0},
            '{ROW_WRITE, REG_KD,     32'd65535,    0,      0,      1'b0, 0,     1'b0},
            '{ROW_WRITE, REG_KP,     32'd65535,    0,      0,      1'b0, 0,     1'b0},
            '{ROW_WRITE, REG_KI,     32'd65535,    0,      0,      1'b0, 0,     1'b0},
            '{ROW_WRITE, REG_LIMIT,  32'd1000,     0,      0,      1'b0, 0,     1'b0},
            '{ROW_ITEM,  REG_KP,     32'd0,        0,      1,      1'b0, 0,     1'b0},
            '{ROW_ITEM,  REG_KP,     32'd0,        0,      0,      1'b0, 0,     1'b0},
            '{ROW_ITEM,  REG_KP,     32'd0,        3,      0,      1'b0, 0,     1'b0},
            // writes to unmapped slots must leave the map alone
            '{ROW_WRITE, REG_SPARE5, 32'hFFFFFFFF, 0,      0,      1'b0, 0,     1'b0},
            '{ROW_WRITE, REG_SPARE7, 32'hFFFFFFFF, 0,      0,      1'b0, 0,     1'b0},
            '{ROW_ITEM,  REG_KP,     32'd0,        -1,     -1,     1'b0, 0,     1'b0},
            '{ROW_WRITE, REG_ALPHA,  32'd0,        0,      0,      1'b0, 0,     1'b0},
            '{ROW_WRITE, REG_KP,     32'd1,        0,      0,      1'b0, 0,     1'b0},
            '{ROW_WRITE, REG_KI,     32'd1,        0,      0,      1'b0, 0,     1'b0},
            '{ROW_WRITE, REG_KD,     32'd256,      0,      0,      1'b0, 0,     1'b0},
            '{ROW_ITEM,  REG_KP,     32'd0,        7,      -7,     1'b0, 0,     1'b0},
            '{ROW_ITEM,  REG_KP,     32'd0,        7,      -7,     1'b0, 0,     1'b0},
            '{ROW_WRITE, REG_ALPHA,  32'd32768,    0,      0,      1'b0, 0,     1'b0},
            '{ROW_ITEM,  REG_KP,     32'd0,        -7,     7,      1'b0, 0,     1'b0}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++) begin
            if (dir_rows[i].kind == ROW_WRITE) begin
                wait_idle();
                write_reg(dir_rows[i].reg_sel, dir_rows[i].value);
            end else begin
                send_item(dir_rows[i].meas, dir_rows[i].tgt, dir_rows[i].pinned,
                          dir_rows[i].pin_drive, dir_rows[i].pin_sat);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            tx_gap_pct   = 0;
            rx_stall_pct = 0;
            for (int r = REG_KP; r <= REG_LIMIT; r++) begin
                sel = $urandom_range(0, 9);
                if (ph == 1)
                    v = '1;
                else if (ph == 2)
                    v = '0;
                else if (r == REG_LIMIT)
                    v = (sel < 2) ? 32'd0 : (sel < 3) ? 32'd8388607 :
                        (sel < 8) ? $urandom_range(0, 2000) : $urandom;
                else if (r == REG_ALPHA)
                    v = (sel < 2) ? 32'd32768 : (sel < 3) ? $urandom_range(32769, 65535) :
                        (sel < 4) ? 32'd0 : $urandom_range(0, 32768);
                else
                    v = (sel < 1) ? 32'd0 : (sel < 2) ? 32'd65535 :
                        (sel < 7) ? $urandom_range(0, 400) : $urandom_range(0, 65535);
                write_reg(3'(r), v);
            end
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_SPARE5, $urandom);
            if (ph != N_PHASES - 1) begin
                tx_gap_pct   = $urandom_range(0, 3) * 15;
                rx_stall_pct = $urandom_range(0, 3) * 15;
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 3 && n == 100)
                    hold_req = 1'b1;
                mode = $urandom_range(0, 99);
                m    = IN_W'($urandom);
                if (mode < 70) begin
                    // tracking: small error around a random operating point
                    tv = int'(m) + int'($urandom_range(0, 80)) - 40;
                    if (tv > 32767) tv = 32767;
                    if (tv < -32768) tv = -32768;
                    t = IN_W'(tv);
                end else if (mode < 85) begin
                    t = IN_W'($urandom);
                end else begin
                    t = m;
                end
                send_item(m, t, 1'b0, '0, 1'b0);
            end
        end

        i_valid <= 1'b0;
        while (drives_seen < samples_sent) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending_drive.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/pidc_pkg.sv
hw/rtl/pid_controller_clamped.sv
bench/tb_pid_controller_clamped.sv
